@@ src/wlmc_pkg.sv @@
// package for the window local-max corner detector
// types, sizes, register indexes and small helpers shared by all wlmc modules
// no dependencies
`default_nettype none

package wlmc_pkg;

  // window geometry
  localparam int unsigned RANGE      = 3;
  localparam int unsigned WIN        = 2 * RANGE + 1;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  // field and counter widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned SLOT_W     = $clog2(WIN);
  localparam int unsigned WORD_W     = WIN * PIX_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESPONSE = 2'd2;

  // register reset values
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 12'd1024;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 12'd1024;
  localparam logic [PIX_W-1:0]  RST_MIN_RESPONSE = 8'd100;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [WORD_W-1:0] word_t;

  // position of one beat after counter adjustment
  typedef struct packed {
    logic             test;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    slot_t            slot;
  } meta_t;

  // one detected corner
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t               value;
  } hit_t;

  // zero counts as one, anything above the maximum is the maximum
  function automatic logic [31:0] clamp_size(logic [SIZE_W-1:0] v, int unsigned mx);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) begin
      r = 32'd1;
    end else if (32'(v) > mx) begin
      r = mx;
    end
    return r;
  endfunction

  // row slot advance, modulo the window height
  function automatic slot_t slot_inc(slot_t s);
    slot_t r;
    r = (s == SLOT_W'(WIN - 1)) ? '0 : s + SLOT_W'(1);
    return r;
  endfunction

  // slot of the row RANGE above the given one
  function automatic slot_t slot_center(slot_t s);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + (SLOT_W + 1)'(WIN - RANGE);
    if (t >= (SLOT_W + 1)'(WIN)) begin
      t = t - (SLOT_W + 1)'(WIN);
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/wlmc_pos.sv @@
// configuration registers and raster position counters
// gives column, row, row slot and window test flag of each accepted beat
// depends on wlmc_pkg
`default_nettype none

module wlmc_pos (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wlmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wlmc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             accept_i,
  input  logic                             start_of_frame_i,
  output wlmc_pkg::meta_t                  beat_o,
  output wlmc_pkg::pix_t                   min_response_o
);
  import wlmc_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  pix_t              min_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  slot_t             slot_q, slot_d;

  logic [31:0]       w_full, h_full;
  logic [COL_W:0]    w_eff, c0, c1, c3;
  logic [ROW_W:0]    h_eff, r0, r1, r3;
  logic [COL_W-1:0]  c2;
  logic [ROW_W-1:0]  r2;
  slot_t             s0, s1, s2;

  // effective frame size
  assign w_full = clamp_size(width_q, MAX_WIDTH);
  assign h_full = clamp_size(height_q, MAX_HEIGHT);
  assign w_eff  = w_full[COL_W:0];
  assign h_eff  = h_full[ROW_W:0];

  // position of this beat, then position of the next one
  always_comb begin
    c0 = start_of_frame_i ? '0 : {1'b0, col_q};
    r0 = start_of_frame_i ? '0 : {1'b0, row_q};
    s0 = start_of_frame_i ? '0 : slot_q;

    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + (ROW_W + 1)'(1);
      s1 = slot_inc(s0);
    end else begin
      c1 = c0;
      r1 = r0;
      s1 = s0;
    end
    c2 = c1[COL_W-1:0];

    if (r1 >= h_eff) begin
      r2 = '0;
      s2 = '0;
    end else begin
      r2 = r1[ROW_W-1:0];
      s2 = s1;
    end

    beat_o.test = (c2 >= COL_W'(2 * RANGE)) && (r2 >= ROW_W'(2 * RANGE));
    beat_o.col  = c2;
    beat_o.row  = r2;
    beat_o.slot = s2;

    c3 = {1'b0, c2} + (COL_W + 1)'(1);
    r3 = {1'b0, r2} + (ROW_W + 1)'(1);
    if (c3 >= w_eff) begin
      col_d = '0;
      if (r3 >= h_eff) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = r3[ROW_W-1:0];
        slot_d = slot_inc(s2);
      end
    end else begin
      col_d  = c3[COL_W-1:0];
      row_d  = r2;
      slot_d = s2;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      min_q    <= RST_MIN_RESPONSE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_MIN_RESPONSE: min_q    <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  assign min_response_o = min_q;

endmodule

`default_nettype wire

@@ src/wlmc_line_store.sv @@
// line store: one word per column holding one byte per row slot
// byte write of the new pixel and full-column read in the same cycle
// depends on wlmc_pkg
`default_nettype none

module wlmc_line_store (
  input  logic            clk_i,
  input  logic            accept_i,
  input  wlmc_pkg::meta_t beat_i,
  input  wlmc_pkg::pix_t  pix_i,
  output wlmc_pkg::word_t word_o
);
  import wlmc_pkg::*;

  word_t mem [MAX_WIDTH];
  word_t rd_q;
  pix_t  pix_q;
  slot_t slot_q;

  // read old column, write new byte into its row slot
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q   <= mem[beat_i.col];
      pix_q  <= pix_i;
      slot_q <= beat_i.slot;
      for (int b = 0; b < WIN; b++) begin
        if (beat_i.slot == SLOT_W'(b)) begin
          mem[beat_i.col][b*PIX_W +: PIX_W] <= pix_i;
        end
      end
    end
  end

  // forward the byte written by the same beat
  always_comb begin
    word_o = rd_q;
    for (int b = 0; b < WIN; b++) begin
      if (slot_q == SLOT_W'(b)) begin
        word_o[b*PIX_W +: PIX_W] = pix_q;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/wlmc_window.sv @@
// window stage: per-column max/min shift line and center column words
// reduces the window and decides whether the center is a corner
// depends on wlmc_pkg
`default_nettype none

module wlmc_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            s1_valid_i,
  input  wlmc_pkg::meta_t s1_meta_i,
  input  wlmc_pkg::word_t word_i,
  input  wlmc_pkg::pix_t  min_response_i,
  output logic            hit_valid_o,
  output wlmc_pkg::hit_t  hit_o
);
  import wlmc_pkg::*;

  pix_t  cmax_q [WIN];
  pix_t  cmin_q [WIN];
  word_t cword_q [RANGE + 1];
  logic  s2_valid_q;
  meta_t s2_meta_q;

  pix_t  colmax, colmin;
  pix_t  wmax, wmin, center;
  slot_t cslot;
  logic  shift;

  assign shift = adv_i && s1_valid_i;

  // max and min of the incoming column
  always_comb begin
    colmax = word_i[PIX_W-1:0];
    colmin = word_i[PIX_W-1:0];
    for (int b = 1; b < WIN; b++) begin
      if (word_i[b*PIX_W +: PIX_W] > colmax) colmax = word_i[b*PIX_W +: PIX_W];
      if (word_i[b*PIX_W +: PIX_W] < colmin) colmin = word_i[b*PIX_W +: PIX_W];
    end
  end

  // column shift line
  always_ff @(posedge clk_i) begin
    if (shift) begin
      cmax_q[0]  <= colmax;
      cmin_q[0]  <= colmin;
      cword_q[0] <= word_i;
      s2_meta_q  <= s1_meta_i;
      for (int k = 1; k < WIN; k++) begin
        cmax_q[k] <= cmax_q[k-1];
        cmin_q[k] <= cmin_q[k-1];
      end
      for (int k = 1; k <= RANGE; k++) begin
        cword_q[k] <= cword_q[k-1];
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  // window reduction and center pick
  always_comb begin
    wmax = cmax_q[0];
    wmin = cmin_q[0];
    for (int k = 1; k < WIN; k++) begin
      if (cmax_q[k] > wmax) wmax = cmax_q[k];
      if (cmin_q[k] < wmin) wmin = cmin_q[k];
    end
    cslot  = slot_center(s2_meta_q.slot);
    center = '0;
    for (int b = 0; b < WIN; b++) begin
      if (cslot == SLOT_W'(b)) begin
        center = cword_q[RANGE][b*PIX_W +: PIX_W];
      end
    end
  end

  // center must be the window max, at or above threshold, and window not flat
  assign hit_valid_o = s2_valid_q && s2_meta_q.test && (center >= min_response_i) &&
                       (wmax == center) && (wmin != center);
  assign hit_o.col   = COORD_W'(s2_meta_q.col - COL_W'(RANGE));
  assign hit_o.row   = COORD_W'(s2_meta_q.row - ROW_W'(RANGE));
  assign hit_o.value = center;

endmodule

`default_nettype wire

@@ src/window_local_max_corner_detect.sv @@
// a corner passes the line store read, shift line and output registers; one pixel beat per
// cycle while in_stall_o is low; the line store does one column read and one byte write per
// cycle, and the output register plus a one-entry skid stage decouple the output stall
// reset: position counters to zero, registers to 1024 / 1024 / 100, pipeline empty;
// the line store is not cleared and needs no clearing pass
// top level: position counters, line store, window compare, output skid stage
`default_nettype none

module window_local_max_corner_detect (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wlmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wlmc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wlmc_pkg::PIX_W-1:0]       response_i,
  input  logic                             start_of_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wlmc_pkg::COORD_W-1:0]     corner_column_o,
  output logic [wlmc_pkg::COORD_W-1:0]     corner_row_o,
  output logic [wlmc_pkg::PIX_W-1:0]       corner_value_o
);
  import wlmc_pkg::*;

  logic  adv, accept;
  meta_t beat;
  pix_t  min_response;
  logic  s1_valid_q;
  meta_t s1_meta_q;
  word_t col_word;
  logic  hit_valid;
  hit_t  hit;
  logic  out_valid_q, skid_valid_q;
  hit_t  out_q, skid_q;

  // pipeline moves whenever the skid stage is empty
  assign adv        = !skid_valid_q;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = skid_valid_q;

  wlmc_pos u_pos (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .start_of_frame_i(start_of_frame_i),
    .beat_o          (beat),
    .min_response_o  (min_response)
  );

  wlmc_line_store u_line_store (
    .clk_i   (clk_i),
    .accept_i(accept),
    .beat_i  (beat),
    .pix_i   (response_i),
    .word_o  (col_word)
  );

  // memory read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= beat;
    end
  end

  wlmc_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .s1_valid_i    (s1_valid_q),
    .s1_meta_i     (s1_meta_q),
    .word_i        (col_word),
    .min_response_i(min_response),
    .hit_valid_o   (hit_valid),
    .hit_o         (hit)
  );

  // output register and skid valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && out_stall_i) begin
      skid_valid_q <= hit_valid;
    end else begin
      out_valid_q <= hit_valid;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && out_stall_i) begin
      if (hit_valid) begin
        skid_q <= hit;
      end
    end else if (hit_valid) begin
      out_q <= hit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign corner_column_o = out_q.col;
  assign corner_row_o    = out_q.row;
  assign corner_value_o  = out_q.value;

`ifndef SYNTHESIS
  // a beat in the skid stage always has one in front of it
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while the output register is empty");

  // skid fills only behind a stalled output beat
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  // skid drains only when the output beat is taken
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_valid_q) |-> $past(!out_stall_i))
    else $error("skid drained while output was stalled");
`endif

endmodule

`default_nettype wire

@@ tb/wlmc_corner_check.sv @@
`timescale 1ns / 100ps
// corner checker for window_local_max_corner_detect: watches the register port and both
// beat channels, keeps its own line store and window compare, and checks every corner beat
// depends on wlmc_pkg only

module wlmc_corner_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wlmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wlmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [wlmc_pkg::PIX_W-1:0]      response_i,
  input  logic                            start_of_frame_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [wlmc_pkg::COORD_W-1:0]    corner_column_i,
  input  logic [wlmc_pkg::COORD_W-1:0]    corner_row_i,
  input  logic [wlmc_pkg::PIX_W-1:0]      corner_value_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     corners_o
);
  import wlmc_pkg::*;

  // shadow registers and position counters
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  pix_t              min_q;
  int unsigned       col_pos;
  int unsigned       row_pos;

  // recent rows, indexed by row modulo the window height
  pix_t line_mem [WIN][MAX_WIDTH];

  // corners predicted but not yet seen on the output
  hit_t pending_corners [$];

  int unsigned mismatch_count = 0;
  int unsigned pending_count  = 0;
  int unsigned corners_seen   = 0;

  assign error_count_o = mismatch_count;
  assign pending_o     = pending_count;
  assign corners_o     = corners_seen;

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned fit_size(logic [SIZE_W-1:0] v, int unsigned top_size);
    if (v == '0) return 1;
    if (32'(v) > top_size) return top_size;
    return 32'(v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned w;
    int unsigned h;
    int unsigned cc;
    int unsigned cr;
    int unsigned r;
    int unsigned c;
    pix_t        v;
    pix_t        lo;
    bit          peak;
    hit_t        hit;
    hit_t        want;
    if (!rst_ni) begin
      width_q  = RST_IMAGE_WIDTH;
      height_q = RST_IMAGE_HEIGHT;
      min_q    = RST_MIN_RESPONSE;
      col_pos  = 0;
      row_pos  = 0;
      pending_corners.delete();
      pending_count = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_q = cfg_data_i[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT: height_q = cfg_data_i[SIZE_W-1:0];
          CFG_MIN_RESPONSE: min_q = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end

      // pixel beat: store it, then test the center of the window it completes
      if (in_valid_i && !in_stall_i) begin
        w = fit_size(width_q, MAX_WIDTH);
        h = fit_size(height_q, MAX_HEIGHT);
        if (start_of_frame_i) begin
          col_pos = 0;
          row_pos = 0;
        end
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        line_mem[row_pos % WIN][col_pos] = response_i;

        if (col_pos >= 2 * RANGE && row_pos >= 2 * RANGE) begin
          cc = col_pos - RANGE;
          cr = row_pos - RANGE;
          v  = line_mem[cr % WIN][cc];
          if (v >= min_q) begin
            lo   = 8'hFF;
            peak = 1'b1;
            for (r = row_pos - 2 * RANGE; r <= row_pos; r++) begin
              for (c = col_pos - 2 * RANGE; c <= col_pos; c++) begin
                if (line_mem[r % WIN][c] < lo) lo = line_mem[r % WIN][c];
                if (line_mem[r % WIN][c] > v) peak = 1'b0;
              end
            end
            // flat windows never count as a corner
            if (peak && lo != v) begin
              hit.col   = COORD_W'(cc);
              hit.row   = COORD_W'(cr);
              hit.value = v;
              pending_corners = {pending_corners, hit};
            end
          end
        end

        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end

      // corner beat: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        corners_seen++;
        if (pending_corners.size() == 0) begin
          $error("corner with nothing predicted: column %0d row %0d value %0d",
                 corner_column_i, corner_row_i, corner_value_i);
          mismatch_count++;
        end else begin
          want = pending_corners.pop_front();
          if (corner_column_i !== want.col) begin
            $error("corner_column: expected %0d, actual %0d", want.col, corner_column_i);
            mismatch_count++;
          end
          if (corner_row_i !== want.row) begin
            $error("corner_row: expected %0d, actual %0d", want.row, corner_row_i);
            mismatch_count++;
          end
          if (corner_value_i !== want.value) begin
            $error("corner_value: expected %0d, actual %0d", want.value, corner_value_i);
            mismatch_count++;
          end
        end
      end
      pending_count = pending_corners.size();
    end
  end

endmodule

@@ tb/window_local_max_corner_detect_test.sv @@
`timescale 1ns / 100ps
// regression top for window_local_max_corner_detect: clock, reset, register writes,
// pixel stimulus and output stall; checking is done by wlmc_corner_check
// depends on wlmc_pkg, window_local_max_corner_detect and wlmc_corner_check

module window_local_max_corner_detect_test;
  import wlmc_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_NS     = 2_000_000;
  localparam int unsigned CLAMP_BEATS  = 64;

  // pixel textures for one phase
  typedef enum int unsigned {TEX_UNIFORM, TEX_SPARSE, TEX_TIES, TEX_FLAT} texture_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      response;
  logic                  start_of_frame;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    corner_column;
  logic [COORD_W-1:0]    corner_row;
  logic [PIX_W-1:0]      corner_value;

  int unsigned error_count;
  int unsigned pending;
  int unsigned corners;

  int unsigned send_gap = 16;
  int unsigned recv_gap = 63;
  bit          hold_req = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned settings_applied = 0;

  window_local_max_corner_detect dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .response_i       (response),
    .start_of_frame_i (start_of_frame),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .corner_column_o  (corner_column),
    .corner_row_o     (corner_row),
    .corner_value_o   (corner_value)
  );

  wlmc_corner_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .response_i       (response),
    .start_of_frame_i (start_of_frame),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .corner_column_i  (corner_column),
    .corner_row_i     (corner_row),
    .corner_value_i   (corner_value),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .corners_o        (corners)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // hard stop
  initial begin
    #(LIMIT_NS);
    $display("window_local_max_corner_detect regression: fail");
    $finish;
  end

  // output stall: random, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_gap);
      end
    end
  end

  // one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input pix_t pix, input logic sof);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    response       <= pix;
    start_of_frame <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // a run of pixels laid out as frames of cols x rows
  task automatic send_pixels(input int unsigned cols, input int unsigned rows,
                             input int unsigned npix, input texture_e tex, input pix_t base,
                             input bit sof_first, input bit noise);
    int unsigned p;
    logic        sof;
    pix_t        pix;
    for (p = 0; p < npix; p++) begin
      sof = 1'b0;
      if (p == 0) sof = sof_first;
      else if (p % (cols * rows) == 0) sof = $urandom_range(1);
      // stray frame restart
      if (noise && $urandom_range(255) == 0) sof = 1'b1;
      case (tex)
        TEX_SPARSE: pix = ($urandom_range(9) == 0) ? pix_t'($urandom_range(255, 150))
                                                   : pix_t'($urandom_range(20));
        TEX_TIES:   pix = base ^ pix_t'($urandom_range(1));
        TEX_FLAT:   pix = ($urandom_range(39) == 0) ? base ^ 8'h01 : base;
        default:    pix = pix_t'($urandom_range(255));
      endcase
      send_pixel(pix, sof);
    end
  endtask

  // register writes back to back; mask picks width, height, min_response
  task automatic apply_config(input logic [SIZE_W-1:0] wreg, input logic [SIZE_W-1:0] hreg,
                              input pix_t mreg, input logic [2:0] mask);
    logic [CFG_IDX_W-1:0]  idxs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    int                    i;
    idxs[0] = CFG_IMAGE_WIDTH;
    idxs[1] = CFG_IMAGE_HEIGHT;
    idxs[2] = CFG_MIN_RESPONSE;
    vals[0] = wreg;
    vals[1] = hreg;
    vals[2] = CFG_DATA_W'(mreg);
    for (i = 0; i < 3; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= idxs[i];
        cfg_data  <= vals[i];
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // stop sending, wait for every predicted corner, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned p;
    int unsigned random_start;
    int unsigned phase_no;
    int unsigned wreg;
    int unsigned hreg;
    int unsigned cols;
    int unsigned rows;
    int unsigned npix;
    pix_t        mreg;
    pix_t        base;
    texture_e    tex;
    logic [2:0]  mask;
    bit          noise;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IMAGE_WIDTH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    response       = '0;
    start_of_frame = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero sizes act as one pixel: no window ever completes
    apply_config(12'd0, 12'd0, 8'd0, 3'b111);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hAA, 1'b1);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hFF, 1'b0);
    wait_idle();

    // smallest frame with a full-scale center and the top threshold
    apply_config(12'd7, 12'd7, 8'hFF, 3'b111);
    for (p = 0; p < 49; p++) begin
      send_pixel((p == 24) ? 8'hFF : ((p == 0) ? 8'h00 : pix_t'($urandom_range(254))),
                 p == 0);
    end
    wait_idle();

    // random phases: receiver idles, then sender idles, then neither
    random_start = beats_sent;
    phase_no     = 0;
    while (beats_sent - random_start < RANDOM_BEATS || phase_no < 3) begin
      if (phase_no == 0) begin
        send_gap = 16;
        recv_gap = 63;
      end else if (phase_no == 1) begin
        send_gap = 63;
        recv_gap = 16;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end

      case ($urandom_range(19))
        0:       wreg = $urandom_range(6);
        1:       wreg = $urandom_range(64, 25);
        default: wreg = $urandom_range(24, 7);
      endcase
      hreg = ($urandom_range(19) == 0) ? $urandom_range(6) : $urandom_range(16, 7);
      tex  = texture_e'($urandom_range(3));
      case ($urandom_range(3))
        0:       base = 8'h00;
        1:       base = 8'hFF;
        default: base = pix_t'($urandom_range(255));
      endcase
      case ($urandom_range(9))
        0:       mreg = 8'h00;
        1:       mreg = 8'hFF;
        2, 3:    mreg = base;
        default: mreg = pix_t'($urandom_range(255));
      endcase
      mask  = ($urandom_range(4) == 0 && phase_no != 0) ? 3'b011 : 3'b111;
      noise = ($urandom_range(4) == 0);

      // long output hold-off on a corner-rich phase, input keeps coming
      if (phase_no == 0) begin
        wreg  = 16;
        hreg  = 16;
        tex   = TEX_SPARSE;
        mreg  = 8'h00;
        mask  = 3'b111;
        noise = 1'b0;
      end

      cols = (wreg == 0) ? 1 : wreg;
      rows = (hreg == 0) ? 1 : hreg;
      npix = cols * rows * $urandom_range(3, 1);
      if (phase_no == 0) npix = cols * rows * 2;
      else if ($urandom_range(6) == 0) npix = $urandom_range(npix, 1);

      apply_config(SIZE_W'(wreg), SIZE_W'(hreg), mreg, mask);
      if (phase_no == 0) hold_req <= 1'b1;
      send_pixels(cols, rows, npix, tex, base, 1'b1, noise);
      wait_idle();
      phase_no++;
    end

    // height and threshold changed with the counters mid-frame; row wraps at once
    apply_config(12'd12, 12'd12, 8'd50, 3'b111);
    send_pixels(12, 12, 12 * 9 + 5, TEX_UNIFORM, 8'h00, 1'b1, 1'b0);
    wait_idle();
    apply_config(12'd12, 12'd8, 8'd30, 3'b110);
    send_pixels(12, 8, 200, TEX_UNIFORM, 8'h00, 1'b0, 1'b0);
    wait_idle();

    // flat full-scale window at the top threshold
    apply_config(12'd9, 12'd9, 8'hFF, 3'b111);
    send_pixels(9, 9, 81, TEX_FLAT, 8'hFF, 1'b1, 1'b0);
    wait_idle();

    // oversize width register, row held to the widest row
    apply_config(12'hFFF, 12'd7, 8'd200, 3'b111);
    send_pixels(MAX_WIDTH, 7, CLAMP_BEATS, TEX_SPARSE, 8'h00, 1'b1, 1'b0);
    wait_idle();

    // oversize height register, frame held to the tallest frame
    apply_config(12'd7, 12'hFFF, 8'd200, 3'b111);
    send_pixels(7, MAX_HEIGHT, CLAMP_BEATS, TEX_SPARSE, 8'h00, 1'b1, 1'b0);
    wait_idle();

    $display("covered %0d pixel beats under %0d register settings, %0d corner beats checked",
             beats_sent, settings_applied, corners);
    $display("sizes from degenerate to oversize, flat and tied windows, long output hold");
    if (error_count == 0 && pending == 0) begin
      $display("window_local_max_corner_detect regression: pass");
    end else begin
      $display("window_local_max_corner_detect regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/wlmc_pkg.sv
src/wlmc_pos.sv
src/wlmc_line_store.sv
src/wlmc_window.sv
src/window_local_max_corner_detect.sv
tb/wlmc_corner_check.sv
tb/window_local_max_corner_detect_test.sv
